// ----- rtl/sbac_pkg.sv -----
// shared types and constants for the block-average sensor converter
// used by sbac_front, sbac_queue, sbac_back and sensor_block_average_convert
// no dependencies
`default_nettype none

package sbac_pkg;

   // channel codes
   localparam int CHANNELS = 3;
   localparam logic [1:0] CH_TEMP  = 2'd0;
   localparam logic [1:0] CH_HUMID = 2'd1;
   localparam logic [1:0] CH_CO2   = 2'd2;

   // per-channel state widths (sum holds up to 16 * 1023)
   localparam int SUM_W   = 14;
   localparam int COUNT_W = 4;
   localparam int SAMPLE_W = 10;
   localparam int VALUE_W = 15;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QFILL_W     = 3;

   // average by reciprocal: sum * ceil(2^WIN_SHIFT / window) >> WIN_SHIFT
   localparam int WIN_SHIFT   = 24;
   localparam int WIN_RECIP_W = 25;
   localparam int WIN_PROD_W  = SUM_W + WIN_RECIP_W;

   // unit conversion: average times a scale, less an offset for temperature, then divided
   localparam int SCALED_W     = 22;
   localparam int AVG_W        = 10;
   localparam logic [11:0] SCALE_TH  = 12'd488;
   localparam logic [11:0] SCALE_CO2 = 12'd2440;
   localparam logic [SCALED_W-1:0] TEMP_OFFSET = 22'd50000;

   // final division by reciprocal, exact for every magnitude that can occur
   localparam int DIV_SHIFT = 32;
   localparam int RECIP_W   = 25;
   localparam int DIV_PROD_W = SCALED_W + RECIP_W;
   localparam int QUOT_W    = 14;
   localparam logic [RECIP_W-1:0] RECIP_TEMP  =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd999) / 64'd1000);
   localparam logic [RECIP_W-1:0] RECIP_HUMID =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd4999) / 64'd5000);
   localparam logic [RECIP_W-1:0] RECIP_CO2   =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd180) / 64'd181);

   // one completed window, as it travels through the queue
   typedef struct packed {
      logic [1:0]       chan;
      logic [SUM_W-1:0] sum;
   } win_entry_type;

   // head of the queue as the back part sees it
   typedef struct packed {
      logic          valid;
      win_entry_type entry;
   } queue_head_type;

endpackage

`default_nettype wire

// ----- rtl/sbac_front.sv -----
// front part: takes sample words, keeps per-channel running sums and counts
// and hands each completed window to the queue
// depends on sbac_pkg
`default_nettype none

module sbac_front #(
   parameter int WINDOW = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_channel,
   input  logic [sbac_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                        q_full,
   output logic                        push,
   output sbac_pkg::win_entry_type     push_entry
);
   import sbac_pkg::*;

   logic [SUM_W-1:0]   sum_ff   [CHANNELS];
   logic [SUM_W-1:0]   sum_in   [CHANNELS];
   logic [COUNT_W-1:0] count_ff [CHANNELS];
   logic [COUNT_W-1:0] count_in [CHANNELS];

   logic               accept;
   logic               chan_ok;
   logic [SUM_W-1:0]   new_sum;
   logic [COUNT_W-1:0] new_count;
   logic               fire;

   // word accepted whenever the queue has room
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign chan_ok   = (req_channel == CH_TEMP) || (req_channel == CH_HUMID) ||
                      (req_channel == CH_CO2);

   // add the sample to its channel; window closes on reaching the length
   always_comb begin
      new_sum   = '0;
      new_count = '0;
      if (chan_ok) begin
         new_sum   = sum_ff[req_channel] + SUM_W'(req_sample);
         new_count = count_ff[req_channel] + COUNT_W'(1);
      end
   end

   assign fire = ({1'b0, new_count} >= 5'(WINDOW)) || (new_count == '0);

   // next state per channel
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         sum_in[c]   = sum_ff[c];
         count_in[c] = count_ff[c];
         if (accept && chan_ok && (req_channel == 2'(c))) begin
            if (fire) begin
               sum_in[c]   = '0;
               count_in[c] = '0;
            end else begin
               sum_in[c]   = new_sum;
               count_in[c] = new_count;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c]   <= '0;
            count_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c]   <= sum_in[c];
            count_ff[c] <= count_in[c];
         end
      end
   end

   // completed window goes to the queue
   assign push            = accept && chan_ok && fire;
   assign push_entry.chan = req_channel;
   assign push_entry.sum  = new_sum;

`ifndef NO_ASSERTIONS
   a_count_below_window: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, count_ff[0]} < 5'(WINDOW)) && ({1'b0, count_ff[1]} < 5'(WINDOW)) &&
      ({1'b0, count_ff[2]} < 5'(WINDOW)))
      else $error("window count reached the window length");
`endif

endmodule

`default_nettype wire

// ----- rtl/sbac_queue.sv -----
// short queue of completed windows between the front and back parts
// depends on sbac_pkg
`default_nettype none

module sbac_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  sbac_pkg::win_entry_type      push_entry,
   output logic                         full,
   input  logic                         pop,
   output sbac_pkg::queue_head_type     head
);
   import sbac_pkg::*;

   win_entry_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QFILL_W-1:0]   fill_ff, fill_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (fill_ff == QFILL_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (fill_ff != '0);

   // pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + QFILL_W'(1);
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - QFILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head.valid = (fill_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("window pushed into a full queue");
   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QFILL_W'(QUEUE_DEPTH))
      else $error("queue fill level out of range");
   a_pop_moves_head: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (fill_ff == $past(fill_ff) - QFILL_W'(1)))
      else $error("pop did not lower the fill level");
`endif

endmodule

`default_nettype wire

// ----- rtl/sbac_back.sv -----
// back part: averages each completed window and converts it to units
// five-stage pipeline that stalls as a whole on the result channel
// depends on sbac_pkg
`default_nettype none

module sbac_back #(
   parameter int WINDOW = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sbac_pkg::queue_head_type      head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_out_channel,
   output logic signed [sbac_pkg::VALUE_W-1:0] rsp_value
);
   import sbac_pkg::*;

   localparam logic [WIN_RECIP_W-1:0] WIN_RECIP =
      WIN_RECIP_W'(((64'd1 << WIN_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   logic                    adv;

   logic                    s1_valid_ff, s1_valid_in;
   logic [1:0]              s1_chan_ff, s1_chan_in;
   logic [WIN_PROD_W-1:0]   s1_prod_ff, s1_prod_in;

   logic                    s2_valid_ff, s2_valid_in;
   logic [1:0]              s2_chan_ff, s2_chan_in;
   logic [SCALED_W-1:0]     s2_scaled_ff, s2_scaled_in;

   logic                    s3_valid_ff, s3_valid_in;
   logic [1:0]              s3_chan_ff, s3_chan_in;
   logic                    s3_neg_ff, s3_neg_in;
   logic [SCALED_W-1:0]     s3_mag_ff, s3_mag_in;

   logic                    s4_valid_ff, s4_valid_in;
   logic [1:0]              s4_chan_ff, s4_chan_in;
   logic                    s4_neg_ff, s4_neg_in;
   logic [DIV_PROD_W-1:0]   s4_prod_ff, s4_prod_in;

   logic                    out_valid_ff, out_valid_in;
   logic [1:0]              out_chan_ff, out_chan_in;
   logic [VALUE_W-1:0]      out_value_ff, out_value_in;

   logic [AVG_W-1:0]        avg;
   logic [11:0]             scale;
   logic [RECIP_W-1:0]      recip;
   logic [QUOT_W-1:0]       quot;
   logic [VALUE_W-1:0]      quot_ext;

   // whole pipe moves unless a result word is held by the receiver
   assign adv = !out_valid_ff || !rsp_stall;
   assign pop = adv && head.valid;

   // stage 1: sum times window reciprocal
   assign s1_valid_in = head.valid;
   assign s1_chan_in  = head.entry.chan;
   assign s1_prod_in  = WIN_PROD_W'(head.entry.sum) * WIN_PROD_W'(WIN_RECIP);

   // stage 2: average times channel scale
   assign avg = s1_prod_ff[WIN_SHIFT +: AVG_W];
   always_comb begin
      case (s1_chan_ff)
         CH_CO2:  scale = SCALE_CO2;
         default: scale = SCALE_TH;
      endcase
   end
   assign s2_valid_in  = s1_valid_ff;
   assign s2_chan_in   = s1_chan_ff;
   assign s2_scaled_in = SCALED_W'(avg) * SCALED_W'(scale);

   // stage 3: temperature offset, split into sign and magnitude
   always_comb begin
      s3_neg_in = 1'b0;
      s3_mag_in = s2_scaled_ff;
      if (s2_chan_ff == CH_TEMP) begin
         if (s2_scaled_ff < TEMP_OFFSET) begin
            s3_neg_in = 1'b1;
            s3_mag_in = TEMP_OFFSET - s2_scaled_ff;
         end else begin
            s3_mag_in = s2_scaled_ff - TEMP_OFFSET;
         end
      end
   end
   assign s3_valid_in = s2_valid_ff;
   assign s3_chan_in  = s2_chan_ff;

   // stage 4: magnitude times divisor reciprocal
   always_comb begin
      case (s3_chan_ff)
         CH_TEMP:  recip = RECIP_TEMP;
         CH_HUMID: recip = RECIP_HUMID;
         default:  recip = RECIP_CO2;
      endcase
   end
   assign s4_valid_in = s3_valid_ff;
   assign s4_chan_in  = s3_chan_ff;
   assign s4_neg_in   = s3_neg_ff;
   assign s4_prod_in  = DIV_PROD_W'(s3_mag_ff) * DIV_PROD_W'(recip);

   // stage 5: quotient, sign restored, truncating toward zero
   assign quot         = s4_prod_ff[DIV_SHIFT +: QUOT_W];
   assign quot_ext     = {1'b0, quot};
   assign out_valid_in = s4_valid_ff;
   assign out_chan_in  = s4_chan_ff;
   assign out_value_in = s4_neg_ff ? (~quot_ext + VALUE_W'(1)) : quot_ext;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_chan_ff   <= s1_chan_in;
         s1_prod_ff   <= s1_prod_in;
         s2_chan_ff   <= s2_chan_in;
         s2_scaled_ff <= s2_scaled_in;
         s3_chan_ff   <= s3_chan_in;
         s3_neg_ff    <= s3_neg_in;
         s3_mag_ff    <= s3_mag_in;
         s4_chan_ff   <= s4_chan_in;
         s4_neg_ff    <= s4_neg_in;
         s4_prod_ff   <= s4_prod_in;
         out_chan_ff  <= out_chan_in;
         out_value_ff <= out_value_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_channel = out_chan_ff;
   assign rsp_value       = $signed(out_value_ff);

`ifndef NO_ASSERTIONS
   a_value_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value >= -15'sd50) && (rsp_value <= 15'sd13791))
      else $error("converted value out of range");
   a_neg_only_temp: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && s4_neg_ff) |-> (s4_chan_ff == CH_TEMP))
      else $error("negative value on a channel other than temperature");
`endif

endmodule

`default_nettype wire

// ----- rtl/sensor_block_average_convert.sv -----
// Block-average sensor converter. Takes one sample word per cycle on req_,
// keeps a running sum per channel (0 temperature, 1 humidity, 2 CO2) and,
// each time a channel has taken WINDOW samples, gives one word on rsp_ with
// that channel and its average in degrees C, percent RH or ppm; channel 3 is
// taken and ignored. Sustained rate is one sample per cycle while the queue
// has room. The sample that closes a window passes through a four-entry queue
// of completed windows and then a five-stage conversion pipeline; req_stall
// rises only while that queue is full, which happens when rsp_stall holds the
// pipeline back.
// depends on sbac_pkg, sbac_front, sbac_queue, sbac_back
`default_nettype none

module sensor_block_average_convert #(
   parameter int WINDOW = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_channel,
   input  logic [sbac_pkg::SAMPLE_W-1:0]       req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_out_channel,
   output logic signed [sbac_pkg::VALUE_W-1:0] rsp_value
);
   import sbac_pkg::*;

   logic           push;
   win_entry_type  push_entry;
   logic           q_full;
   logic           pop;
   queue_head_type head;

   // accept and accumulate
   sbac_front #(
      .WINDOW (WINDOW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_channel (req_channel),
      .req_sample  (req_sample),
      .q_full      (q_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   // completed windows waiting for conversion
   sbac_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head       (head)
   );

   // average and convert
   sbac_back #(
      .WINDOW (WINDOW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_value       (rsp_value)
   );

endmodule

`default_nettype wire

// ----- tb/sbac_average_check.sv -----
// watches the req_ and rsp_ sides of the block-average sensor converter, predicts each reading
// from the accepted sample words and compares it with the words that come out
// depends on sbac_pkg
`timescale 1ns / 100ps

module sbac_average_check #(
   parameter int WINDOW = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [1:0]                          req_channel,
   input  logic [sbac_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [1:0]                          rsp_out_channel,
   input  logic signed [sbac_pkg::VALUE_W-1:0] rsp_value,
   output int                                  mismatch_count,
   output int                                  readings_due
);

   typedef struct {
      logic [1:0]                    chan;
      logic [sbac_pkg::VALUE_W-1:0]  value;
   } reading_t;

   // own copy of the per-channel windows
   logic [sbac_pkg::SUM_W-1:0]   window_total [sbac_pkg::CHANNELS];
   logic [sbac_pkg::COUNT_W-1:0] window_taken [sbac_pkg::CHANNELS];
   reading_t                     expected_readings [$];
   int                           fail_total;

   // average of a full window, scaled to degrees C, percent RH or ppm
   function automatic logic [sbac_pkg::VALUE_W-1:0] convert_average(
      input logic [1:0]                chan,
      input logic [sbac_pkg::SUM_W-1:0] total
   );
      int avg;
      int units;
      avg = int'(total) / WINDOW;
      case (chan)
         sbac_pkg::CH_TEMP:  units = (avg * 488 - 50000) / 1000;
         sbac_pkg::CH_HUMID: units = (avg * 488) / 5000;
         default:            units = (avg * 2440) / 181;
      endcase
      return units[sbac_pkg::VALUE_W-1:0];
   endfunction

   always @(posedge clock) begin : watch
      reading_t                     due;
      logic [sbac_pkg::SUM_W-1:0]   next_total;
      logic [sbac_pkg::COUNT_W-1:0] next_taken;
      if (reset) begin
         for (int c = 0; c < sbac_pkg::CHANNELS; c++) begin
            window_total[c] = '0;
            window_taken[c] = '0;
         end
         expected_readings.delete();
         fail_total = 0;
      end else begin
         // accepted sample word: channel 3 leaves everything untouched
         if (req_valid && !req_stall && req_channel <= sbac_pkg::CH_CO2) begin
            next_total = window_total[req_channel] + sbac_pkg::SUM_W'(req_sample);
            next_taken = window_taken[req_channel] + 1'b1;
            if (next_taken < WINDOW && next_taken != 0) begin
               window_total[req_channel] = next_total;
               window_taken[req_channel] = next_taken;
            end else begin
               due.chan  = req_channel;
               due.value = convert_average(req_channel, next_total);
               expected_readings.push_back(due);
               window_total[req_channel] = '0;
               window_taken[req_channel] = '0;
            end
         end
         // accepted result word against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_readings.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%t: unexpected reading ch %0d value %0d", $realtime,
                           rsp_out_channel, rsp_value);
            end else begin
               due = expected_readings.pop_front();
               if (rsp_out_channel !== due.chan || rsp_value !== $signed(due.value)) begin
                  fail_total++;
                  if (fail_total <= 10)
                     $display("%t: reading mismatch: expected ch %0d value %0d, got ch %0d value %0d",
                              $realtime, due.chan, $signed(due.value), rsp_out_channel,
                              rsp_value);
               end
            end
         end
      end
      mismatch_count <= fail_total;
      readings_due   <= expected_readings.size();
   end

endmodule

// ----- tb/sensor_block_average_convert_test.sv -----
// top of the testbench for the block-average sensor converter: clock, reset,
// sample stimulus, result-side stalls and the verdict
// depends on sbac_pkg, sensor_block_average_convert and sbac_average_check
`timescale 1ns / 100ps

module sensor_block_average_convert_test;

   localparam int         WINDOW       = 10;
   localparam logic [1:0] CH_UNUSED    = 2'd3;
   localparam int         RANDOM_WORDS = 850;
   localparam int         QUIET_START  = 300;
   localparam int         QUIET_END    = 450;
   localparam int         CHOKE_END    = 600;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic [1:0]                    req_channel = '0;
   logic [sbac_pkg::SAMPLE_W-1:0] req_sample  = '0;
   logic                          rsp_stall   = 1'b0;
   wire                           req_stall;
   wire                           rsp_valid;
   wire [1:0]                     rsp_out_channel;
   wire signed [sbac_pkg::VALUE_W-1:0] rsp_value;
   int                            mismatch_count;
   int                            readings_due;
   int                            idle_pct  = 32;
   int                            stall_pct = 32;

   sensor_block_average_convert #(.WINDOW(WINDOW)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_channel(req_channel),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_channel(rsp_out_channel),
      .rsp_value(rsp_value)
   );

   sbac_average_check #(.WINDOW(WINDOW)) average_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_channel(req_channel),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_channel(rsp_out_channel),
      .rsp_value(rsp_value),
      .mismatch_count(mismatch_count),
      .readings_due(readings_due)
   );

   always #1 clock = ~clock;

   // result-side back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // one sample word, after a random number of idle cycles
   task automatic send_sample(input logic [1:0] chan, input logic [sbac_pkg::SAMPLE_W-1:0] smp);
      while ($urandom_range(99) < idle_pct) begin
         req_valid  <= 1'b0;
         req_sample <= sbac_pkg::SAMPLE_W'($urandom);
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_channel <= chan;
      req_sample  <= smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin : stimulus
      int                            n;
      logic [1:0]                    chan;
      logic [sbac_pkg::SAMPLE_W-1:0] smp;
      int                            window_fill [3];
      int                            fill_mode [3];
      logic [sbac_pkg::SAMPLE_W-1:0] fill_level [3];

      for (int c = 0; c < 3; c++) begin
         window_fill[c] = 0;
         fill_mode[c]   = 0;
         fill_level[c]  = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // channel 3 is taken and ignored, at both sample extremes
      send_sample(CH_UNUSED, '0);
      send_sample(CH_UNUSED, '1);
      // full-scale CO2 window interleaved with a zero temperature window
      for (int i = 0; i < WINDOW; i++) begin
         send_sample(sbac_pkg::CH_CO2, '1);
         send_sample(sbac_pkg::CH_TEMP, '0);
      end
      send_sample(CH_UNUSED, 10'h2AA);

      // random words, each window given a fill pattern of its own
      n = 0;
      while (n < RANDOM_WORDS) begin
         if (n == QUIET_START) begin
            // hold back until every reading is out, then run flat out
            req_valid <= 1'b0;
            @(posedge clock);
            while (readings_due != 0) @(posedge clock);
            idle_pct  <= 0;
            stall_pct <= 0;
         end else if (n == QUIET_END) begin
            // heavy result stalls to fill the window queue
            idle_pct  <= 0;
            stall_pct <= 90;
         end else if (n == CHOKE_END) begin
            idle_pct  <= 32;
            stall_pct <= 32;
         end
         if ($urandom_range(99) < 8) begin
            send_sample(CH_UNUSED, sbac_pkg::SAMPLE_W'($urandom));
         end else begin
            chan = 2'($urandom_range(2));
            if (window_fill[chan] == 0) begin
               fill_mode[chan]  = $urandom_range(9);
               fill_level[chan] = sbac_pkg::SAMPLE_W'($urandom);
            end
            case (fill_mode[chan])
               5:       smp = '1;
               6:       smp = '0;
               7:       smp = fill_level[chan];
               8, 9:    smp = sbac_pkg::SAMPLE_W'($urandom_range(3));
               default: smp = sbac_pkg::SAMPLE_W'($urandom);
            endcase
            send_sample(chan, smp);
            window_fill[chan] = (window_fill[chan] + 1) % WINDOW;
            n++;
         end
      end

      // drain, then allow the pipeline time to show any stray word
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_due != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && readings_due == 0) begin
         $display("sensor_block_average_convert_test: PASS");
      end else begin
         $display("sensor_block_average_convert_test: FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("sensor_block_average_convert_test: FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/sbac_pkg.sv
rtl/sbac_front.sv
rtl/sbac_queue.sv
rtl/sbac_back.sv
rtl/sensor_block_average_convert.sv
tb/sbac_average_check.sv
tb/sensor_block_average_convert_test.sv
